// ===== rtl/hbridge_pwm_deadtime_driver_assert.svh =====
// ----------------------------------------------------------------------------
// H-bridge PWM driver assertion macros
// Concurrent check shorthands on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HBRIDGE_PWM_DEADTIME_DRIVER_ASSERT_SVH
`define HBRIDGE_PWM_DEADTIME_DRIVER_ASSERT_SVH

// Same-cycle implication
`define HPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define HPD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hpd_pkg.sv =====
// ----------------------------------------------------------------------------
// hpd_pkg
// Types and constants for the H-bridge PWM driver with dead time.
// ----------------------------------------------------------------------------
package hpd_pkg;

    localparam int DUTY_MAX_DEF = 255;

    localparam int DRIVE_W = 10;              // signed drive width
    localparam int DIFF_W  = DRIVE_W + 1;     // |new - old|
    localparam int DRAIN_W = 16;
    localparam int SETTLE_W = 24;
    localparam int WAIT_W  = DIFF_W + DRAIN_W;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [DRAIN_W-1:0]  DRAIN_RST  = 16'd1000;
    localparam logic [SETTLE_W-1:0] SETTLE_RST = 24'd100000;

    // register word index
    typedef enum logic
    {
        REG_DRAIN  = 1'b0,
        REG_SETTLE = 1'b1
    } reg_idx_t;

    typedef enum logic
    {
        OP_DRIVE = 1'b0,
        OP_TICK  = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        PH_RUN    = 2'd0,
        PH_DRAIN  = 2'd1,
        PH_SETTLE = 2'd2
    } phase_t;

    // gate bit positions
    localparam logic [3:0] G_HL = 4'b0001;
    localparam logic [3:0] G_HR = 4'b0010;
    localparam logic [3:0] G_LL = 4'b0100;
    localparam logic [3:0] G_LR = 4'b1000;
    localparam logic [3:0] G_LOWS = G_LL | G_LR;

endpackage

// ===== rtl/hbridge_pwm_deadtime_driver.sv =====
// ----------------------------------------------------------------------------
// hbridge_pwm_deadtime_driver
// H-bridge gate driver: clamped signed drive, PWM on the low side and a
// drain/settle dead-time sequence on every change of direction.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, opcode, drive         | in
//  out     | out_valid, out_stall, high_left_on,       | out
//          | high_right_on, low_left_on, low_right_on, |
//          | busy_res, clamp_error                     |
//  cfg     | psel, penable, pwrite, paddr, pwdata,     | APB
//          | prdata, pready                            |
//
//  Stages: input register, then state update and result register. One
//  transaction per cycle unless out_stall holds a full result register; the state update feeds back combinationally.
//  Reset clears the state, all gates off, registers to their defaults.
//  out_stall holds the result register and, once the input register is
//  full, stalls the input.
// ----------------------------------------------------------------------------
module hbridge_pwm_deadtime_driver
#(
    parameter int DUTY_MAX = hpd_pkg::DUTY_MAX_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               opcode,
    input  logic signed [hpd_pkg::DRIVE_W-1:0] drive,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               high_left_on,
    output logic                               high_right_on,
    output logic                               low_left_on,
    output logic                               low_right_on,
    output logic                               busy_res,
    output logic                               clamp_error,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hpd_pkg::PADDR_W-1:0]        paddr,
    input  logic [hpd_pkg::PDATA_W-1:0]        pwdata,
    output logic [hpd_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    localparam int DW  = hpd_pkg::DRIVE_W;
    localparam int PW  = $clog2(DUTY_MAX);
    localparam int CW  = (PW > DW) ? PW : DW;
    localparam int WW  = hpd_pkg::WAIT_W;

    // ---------------- configuration ----------------
    logic [hpd_pkg::DRAIN_W-1:0]  drain_reg;
    logic [hpd_pkg::SETTLE_W-1:0] settle_reg;
    logic                         cfg_wr;
    hpd_pkg::reg_idx_t            cfg_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_idx = hpd_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg  <= hpd_pkg::DRAIN_RST;
            settle_reg <= hpd_pkg::SETTLE_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                hpd_pkg::REG_DRAIN:  drain_reg  <= pwdata[hpd_pkg::DRAIN_W-1:0];
                hpd_pkg::REG_SETTLE: settle_reg <= pwdata[hpd_pkg::SETTLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            hpd_pkg::REG_DRAIN:
                prdata = {{(hpd_pkg::PDATA_W-hpd_pkg::DRAIN_W){1'b0}}, drain_reg};
            hpd_pkg::REG_SETTLE:
                prdata = {{(hpd_pkg::PDATA_W-hpd_pkg::SETTLE_W){1'b0}}, settle_reg};
            default:
                prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    logic                 s1_valid_reg;
    hpd_pkg::opcode_t     s1_op_reg;
    logic signed [DW-1:0] s1_drive_reg;
    logic                 out_valid_reg;
    logic                 advance;
    logic                 s1_load;
    logic                 step;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign s1_load  = in_valid && !in_stall;
    assign step     = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_valid_reg || advance)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_op_reg    <= hpd_pkg::opcode_t'(opcode);
            s1_drive_reg <= drive;
        end
    end

    // ---------------- state ----------------
    logic signed [DW-1:0] last_reg, last_next;
    logic signed [DW-1:0] pend_reg, pend_next;
    hpd_pkg::phase_t      phase_reg, phase_next;
    logic [WW-1:0]        wait_reg, wait_next;
    logic [PW-1:0]        pwm_reg, pwm_next;
    logic [3:0]           gate_reg, gate_next;
    logic                 err_reg, err_next;

    logic signed [DW-1:0] v_clamp;
    logic                 v_clipped;
    logic signed [DW:0]   v_diff;
    logic [DW:0]          diff_mag;
    logic [WW-1:0]        drain_prod;
    logic [PW:0]          pwm_inc;
    logic                 go_settle;
    logic                 go_apply;
    logic [DW-1:0]        duty;
    logic                 pwm_on;

    always_comb
    begin
        v_clipped = 1'b0;
        v_clamp   = s1_drive_reg;
        if (int'(s1_drive_reg) > DUTY_MAX)
        begin
            v_clamp   = DW'(DUTY_MAX);
            v_clipped = 1'b1;
        end
        else if (int'(s1_drive_reg) < -DUTY_MAX)
        begin
            v_clamp   = DW'(-DUTY_MAX);
            v_clipped = 1'b1;
        end
        v_diff     = (DW+1)'(v_clamp) - (DW+1)'(last_reg);
        diff_mag   = v_diff[DW] ? (DW+1)'(-v_diff) : (DW+1)'(v_diff);
        drain_prod = WW'(diff_mag) * WW'(drain_reg);
        pwm_inc    = (PW+1)'(pwm_reg) + (PW+1)'(1);
    end

    always_comb
    begin
        last_next  = last_reg;
        pend_next  = pend_reg;
        phase_next = phase_reg;
        wait_next  = wait_reg;
        pwm_next   = pwm_reg;
        gate_next  = gate_reg;
        err_next   = err_reg;
        go_settle  = 1'b0;
        go_apply   = 1'b0;

        case (s1_op_reg)
            hpd_pkg::OP_DRIVE:
            begin
                if (phase_reg == hpd_pkg::PH_RUN)
                begin
                    err_next = err_reg | v_clipped;
                    if ((!last_reg[DW-1] && v_clamp[DW-1]) ||
                        ((last_reg[DW-1] || last_reg == '0) &&
                         !v_clamp[DW-1] && v_clamp != '0))
                    begin
                        // reversal: conducting high side off, drain first
                        pend_next  = v_clamp;
                        gate_next  = gate_reg & ~(v_clamp[DW-1] ? hpd_pkg::G_HL
                                                                : hpd_pkg::G_HR);
                        phase_next = hpd_pkg::PH_DRAIN;
                        wait_next  = drain_prod;
                        go_settle  = (drain_prod == '0);
                    end
                    else
                    begin
                        pend_next = pend_reg;
                        go_apply  = 1'b1;
                    end
                end
            end
            hpd_pkg::OP_TICK:
            begin
                pwm_next = (pwm_inc >= (PW+1)'(DUTY_MAX)) ? '0 : pwm_inc[PW-1:0];
                if (phase_reg != hpd_pkg::PH_RUN)
                begin
                    if (wait_reg != '0)
                    begin
                        wait_next = wait_reg - WW'(1);
                    end
                    if (wait_next == '0)
                    begin
                        if (phase_reg == hpd_pkg::PH_DRAIN)
                        begin
                            go_settle = 1'b1;
                        end
                        else
                        begin
                            go_apply = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (go_settle)
        begin
            gate_next  = gate_next & ~hpd_pkg::G_LOWS;
            phase_next = hpd_pkg::PH_SETTLE;
            wait_next  = WW'(settle_reg);
            if (settle_reg == '0)
            begin
                go_apply = 1'b1;
            end
        end

        if (go_apply)
        begin
            // a plain drive applies the new value, the sequence its pending one
            last_next = (s1_op_reg == hpd_pkg::OP_DRIVE && !go_settle) ? v_clamp
                                                                       : pend_next;
            if (last_next[DW-1])
            begin
                gate_next = hpd_pkg::G_HR | hpd_pkg::G_LL;
            end
            else if (last_next != '0)
            begin
                gate_next = hpd_pkg::G_HL | hpd_pkg::G_LR;
            end
            else
            begin
                gate_next = '0;
            end
            phase_next = hpd_pkg::PH_RUN;
            wait_next  = '0;
        end

        duty   = last_next[DW-1] ? DW'(-last_next) : DW'(last_next);
        pwm_on = CW'(pwm_next) < CW'(duty);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= '0;
            pend_reg  <= '0;
            phase_reg <= hpd_pkg::PH_RUN;
            wait_reg  <= '0;
            pwm_reg   <= '0;
            gate_reg  <= '0;
            err_reg   <= 1'b0;
        end
        else if (step)
        begin
            last_reg  <= last_next;
            pend_reg  <= pend_next;
            phase_reg <= phase_next;
            wait_reg  <= wait_next;
            pwm_reg   <= pwm_next;
            gate_reg  <= gate_next;
            err_reg   <= err_next;
        end
    end

    // ---------------- result register ----------------
    logic res_hl_reg, res_hr_reg, res_ll_reg, res_lr_reg, res_busy_reg, res_err_reg;

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_hl_reg   <= |(gate_next & hpd_pkg::G_HL);
            res_hr_reg   <= |(gate_next & hpd_pkg::G_HR);
            res_ll_reg   <= |(gate_next & hpd_pkg::G_LL) && pwm_on;
            res_lr_reg   <= |(gate_next & hpd_pkg::G_LR) && pwm_on;
            res_busy_reg <= (phase_next != hpd_pkg::PH_RUN);
            res_err_reg  <= err_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign high_left_on  = res_hl_reg;
    assign high_right_on = res_hr_reg;
    assign low_left_on   = res_ll_reg;
    assign low_right_on  = res_lr_reg;
    assign busy_res      = res_busy_reg;
    assign clamp_error   = res_err_reg;

    // ---------------- checks ----------------
`include "hbridge_pwm_deadtime_driver_assert.svh"

    `HPD_ASSERT_IMP(a_no_shoot_through, out_valid_reg, !(res_hl_reg && res_ll_reg) && !(res_hr_reg && res_lr_reg), "high and low side on in one leg")
    `HPD_ASSERT_IMP(a_busy_high_off, out_valid_reg && res_busy_reg, !res_hl_reg && !res_hr_reg, "high side on during dead time")
    `HPD_ASSERT_IMP(a_stall_needs_item, !s1_valid_reg, !in_stall, "input stalled with empty input register")
    `HPD_ASSERT_NXT(a_step_gives_result, step, out_valid_reg, "processed transaction gave no result")

endmodule

// ===== verif/hbridge_pwm_deadtime_driver_checker.sv =====
// ----------------------------------------------------------------------------
// H-bridge PWM driver result checker
// Watches the drive, result and APB channels, keeps its own model of the
// bridge gates and dead-time sequence, and compares every result transaction
// against the oldest predicted gate state.
// ----------------------------------------------------------------------------
module hbridge_pwm_deadtime_driver_checker
#(
    parameter int DUTY_MAX = hpd_pkg::DUTY_MAX_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               opcode,
    input  logic signed [hpd_pkg::DRIVE_W-1:0] drive,

    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic                               high_left_on,
    input  logic                               high_right_on,
    input  logic                               low_left_on,
    input  logic                               low_right_on,
    input  logic                               busy_res,
    input  logic                               clamp_error,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [hpd_pkg::PADDR_W-1:0]        paddr,
    input  logic [hpd_pkg::PDATA_W-1:0]        pwdata,

    output int                                 mismatches,
    output int                                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed
    {
        logic hl;
        logic hr;
        logic ll;
        logic lr;
        logic busy;
        logic err;
    } gate_res_t;

    gate_res_t gates_due[$];

    logic [hpd_pkg::DRAIN_W-1:0]  drain_step;
    logic [hpd_pkg::SETTLE_W-1:0] settle_len;

    int              last_drv;
    int              pend_drv;
    hpd_pkg::phase_t ph;
    int unsigned     wait_left;
    int unsigned     pwm_pos;
    logic [3:0]      gates;
    logic            clamp_seen;

    function automatic int unsigned abs_drive(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void load_drive(int v);
        last_drv = v;
        if (v > 0)
            gates = hpd_pkg::G_HL | hpd_pkg::G_LR;
        else if (v < 0)
            gates = hpd_pkg::G_HR | hpd_pkg::G_LL;
        else
            gates = '0;
        ph = hpd_pkg::PH_RUN;
        wait_left = 0;
    endfunction

    function automatic void begin_settle();
        gates = gates & ~hpd_pkg::G_LOWS;
        ph = hpd_pkg::PH_SETTLE;
        wait_left = settle_len;
        if (wait_left == 0)
            load_drive(pend_drv);
    endfunction

    function automatic void begin_drain(int unsigned diff);
        ph = hpd_pkg::PH_DRAIN;
        wait_left = diff * drain_step;
        if (wait_left == 0)
            begin_settle();
    endfunction

    function automatic gate_res_t bridge_step(logic op,
                                              logic signed [hpd_pkg::DRIVE_W-1:0] d);
        int          v;
        int unsigned duty;
        logic        pwm_on;
        gate_res_t   r;
        if (op == hpd_pkg::OP_DRIVE)
        begin
            // drives arriving mid-sequence are dropped
            if (ph == hpd_pkg::PH_RUN)
            begin
                v = d;
                if (v > DUTY_MAX)
                begin
                    v = DUTY_MAX;
                    clamp_seen = 1'b1;
                end
                else if (v < -DUTY_MAX)
                begin
                    v = -DUTY_MAX;
                    clamp_seen = 1'b1;
                end
                if (last_drv >= 0 && v < 0)
                begin
                    pend_drv = v;
                    gates = gates & ~hpd_pkg::G_HL;
                    begin_drain(abs_drive(v - last_drv));
                end
                else if (last_drv <= 0 && v > 0)
                begin
                    pend_drv = v;
                    gates = gates & ~hpd_pkg::G_HR;
                    begin_drain(abs_drive(v - last_drv));
                end
                else
                begin
                    load_drive(v);
                end
            end
        end
        else
        begin
            pwm_pos = (pwm_pos + 1 >= DUTY_MAX) ? 0 : pwm_pos + 1;
            if (ph != hpd_pkg::PH_RUN)
            begin
                if (wait_left != 0)
                    wait_left--;
                if (wait_left == 0)
                begin
                    if (ph == hpd_pkg::PH_DRAIN)
                        begin_settle();
                    else
                        load_drive(pend_drv);
                end
            end
        end
        duty   = abs_drive(last_drv);
        pwm_on = pwm_pos < duty;
        r.hl   = (gates & hpd_pkg::G_HL) != '0;
        r.hr   = (gates & hpd_pkg::G_HR) != '0;
        r.ll   = ((gates & hpd_pkg::G_LL) != '0) && pwm_on;
        r.lr   = ((gates & hpd_pkg::G_LR) != '0) && pwm_on;
        r.busy = ph != hpd_pkg::PH_RUN;
        r.err  = clamp_seen;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        gate_res_t got;
        gate_res_t want;
        if (!rst_n)
        begin
            drain_step  = hpd_pkg::DRAIN_RST;
            settle_len  = hpd_pkg::SETTLE_RST;
            last_drv    = 0;
            pend_drv    = 0;
            ph          = hpd_pkg::PH_RUN;
            wait_left   = 0;
            pwm_pos     = 0;
            gates       = '0;
            clamp_seen  = 1'b0;
            mismatches  = 0;
            gates_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[hpd_pkg::PADDR_W-1:2] == hpd_pkg::REG_DRAIN)
                    drain_step = pwdata[hpd_pkg::DRAIN_W-1:0];
                else if (paddr[hpd_pkg::PADDR_W-1:2] == hpd_pkg::REG_SETTLE)
                    settle_len = pwdata[hpd_pkg::SETTLE_W-1:0];
            end

            // results first: a result never belongs to a transaction taken this edge
            if (out_valid && !out_stall)
            begin
                got = {high_left_on, high_right_on, low_left_on, low_right_on,
                       busy_res, clamp_error};
                if (gates_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result transaction: %06b (hl hr ll lr busy err)",
                                 got);
                    mismatches++;
                end
                else
                begin
                    want = gates_due.pop_front();
                    if (got.hl != want.hl || got.hr != want.hr || got.ll != want.ll ||
                        got.lr != want.lr || got.busy != want.busy || got.err != want.err)
                    begin
                        if (mismatches < 10)
                            $display("gate mismatch (hl hr ll lr busy err): exp %06b got %06b",
                                     want, got);
                        mismatches++;
                    end
                end
            end

            if (in_valid && !in_stall)
                gates_due.push_back(bridge_step(opcode, drive));

            outstanding <= gates_due.size();
        end
    end

endmodule

// ===== verif/hbridge_pwm_deadtime_driver_test.sv =====
// ----------------------------------------------------------------------------
// H-bridge PWM driver regression
// Directed drive and tick transactions, then random drive/tick sequences over
// a range of dead-time settings, with random idling on both channels and a
// long result stall, ending at the longest dead time. The checker does all prediction and comparison.
// ----------------------------------------------------------------------------
module hbridge_pwm_deadtime_driver_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT      = 600000;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASES           = 10;
    localparam int ITEMS_PER_PHASE  = 150;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               opcode    = 1'b0;
    logic signed [hpd_pkg::DRIVE_W-1:0] drive     = '0;
    logic                               out_stall = 1'b0;
    logic                               psel      = 1'b0;
    logic                               penable   = 1'b0;
    logic                               pwrite    = 1'b0;
    logic [hpd_pkg::PADDR_W-1:0]        paddr     = '0;
    logic [hpd_pkg::PDATA_W-1:0]        pwdata    = '0;

    logic                               in_stall;
    logic                               out_valid;
    logic                               high_left_on;
    logic                               high_right_on;
    logic                               low_left_on;
    logic                               low_right_on;
    logic                               busy_res;
    logic                               clamp_error;
    logic [hpd_pkg::PDATA_W-1:0]        prdata;
    logic                               pready;

    int  mismatches;
    int  outstanding;
    int  cycle_cnt     = 0;
    int  results_taken = 0;
    int  rx_wait       = 0;
    bit  rx_burst      = 1'b0;
    bit  tx_burst      = 1'b0;
    int  items_done    = 0;

    hbridge_pwm_deadtime_driver dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .drive         (drive),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .high_left_on  (high_left_on),
        .high_right_on (high_right_on),
        .low_left_on   (low_left_on),
        .low_right_on  (low_right_on),
        .busy_res      (busy_res),
        .clamp_error   (clamp_error),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    hbridge_pwm_deadtime_driver_checker gate_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .drive         (drive),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .high_left_on  (high_left_on),
        .high_right_on (high_right_on),
        .low_left_on   (low_left_on),
        .low_right_on  (low_right_on),
        .busy_res      (busy_res),
        .clamp_error   (clamp_error),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stall after each transaction, one long hold-off
    always @(posedge clk)
    begin : rx_side
        int g;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                g = rx_burst ? 0 : $urandom_range(0, 6);
                if (results_taken == LONG_HOLD_AT)
                    g = LONG_HOLD_CYCLES;
                results_taken <= results_taken + 1;
                if ($urandom_range(0, 40) == 0)
                    rx_burst <= !rx_burst;
                rx_wait   <= g;
                out_stall <= (g != 0);
            end
            else if (rx_wait > 1)
            begin
                rx_wait   <= rx_wait - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                rx_wait   <= 0;
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(hpd_pkg::opcode_t op, int d);
        int g;
        g = tx_burst ? 0 : $urandom_range(0, 6);
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        drive    <= hpd_pkg::DRIVE_W'(d);
        do
            @(posedge clk);
        while (in_stall);
        if ($urandom_range(0, 40) == 0)
            tx_burst = !tx_burst;
    endtask

    task automatic write_reg(hpd_pkg::reg_idx_t idx, logic [hpd_pkg::PDATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drain the pipeline before touching the dead-time registers
    task automatic set_dead_time(int drain_v, int settle_v);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
        write_reg(hpd_pkg::REG_DRAIN, drain_v);
        write_reg(hpd_pkg::REG_SETTLE, settle_v);
    endtask

    initial
    begin : stimulus
        int drain_cfg;
        int settle_cfg;
        int prev_drv;
        int v;
        int clamped;
        int full;
        int n_ticks;
        int p;
        bit reversal;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults, nothing that starts a sequence
        send_item(hpd_pkg::OP_TICK, 0);
        send_item(hpd_pkg::OP_DRIVE, 0);
        send_item(hpd_pkg::OP_TICK, 1023);

        // shortest dead time: zero settle
        set_dead_time(1, 0);
        send_item(hpd_pkg::OP_DRIVE, 1);       // start from zero counts as reversal
        send_item(hpd_pkg::OP_DRIVE, -512);    // dropped while busy, no clamp flag
        send_item(hpd_pkg::OP_TICK, 0);
        send_item(hpd_pkg::OP_DRIVE, 511);     // clamp, same direction
        send_item(hpd_pkg::OP_TICK, 0);
        send_item(hpd_pkg::OP_TICK, 0);
        send_item(hpd_pkg::OP_DRIVE, 256);
        send_item(hpd_pkg::OP_DRIVE, 0);
        send_item(hpd_pkg::OP_DRIVE, -1);
        send_item(hpd_pkg::OP_DRIVE, 5);
        send_item(hpd_pkg::OP_TICK, 0);
        send_item(hpd_pkg::OP_DRIVE, -512);
        send_item(hpd_pkg::OP_DRIVE, -256);
        send_item(hpd_pkg::OP_TICK, 0);
        send_item(hpd_pkg::OP_DRIVE, -255);
        send_item(hpd_pkg::OP_DRIVE, 0);
        send_item(hpd_pkg::OP_TICK, 0);

        prev_drv = 0;
        for (p = 0; p < PHASES; p++)
        begin
            drain_cfg  = (p == 0) ? 1 : $urandom_range(1, 3);
            settle_cfg = (p % 3 == 0) ? 0 : $urandom_range(0, 12);
            set_dead_time(drain_cfg, settle_cfg);
            while (items_done < (p + 1) * ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        send_item(hpd_pkg::opcode_t'($urandom_range(0, 1)),
                                  $urandom_range(0, 1023));

                if ($urandom_range(0, 7) == 0)
                begin
                    // large drive, mostly in the current direction
                    v = $urandom_range(0, 512);
                    if (prev_drv != 0 && !(drain_cfg == 1 && $urandom_range(0, 3) == 0))
                    begin
                        if (prev_drv < 0)
                            v = -v;
                    end
                    else if ($urandom_range(0, 1) == 0)
                    begin
                        v = -v;
                    end
                    if (v > 511)
                        v = 511;
                end
                else
                begin
                    v = $urandom_range(0, 16) - 8;
                end
                send_item(hpd_pkg::OP_DRIVE, v);
                items_done++;

                clamped = (v > hpd_pkg::DUTY_MAX_DEF) ? hpd_pkg::DUTY_MAX_DEF :
                          (v < -hpd_pkg::DUTY_MAX_DEF) ? -hpd_pkg::DUTY_MAX_DEF : v;
                reversal = (prev_drv >= 0 && clamped < 0) ||
                           (prev_drv <= 0 && clamped > 0);
                full = 0;
                if (reversal)
                    full = ((clamped > prev_drv) ? clamped - prev_drv : prev_drv - clamped)
                           * drain_cfg + settle_cfg + 1;
                n_ticks = full + $urandom_range(0, 4);
                if ($urandom_range(0, 5) == 0)
                    n_ticks = $urandom_range(0, n_ticks);   // cut the sequence short
                if (n_ticks > 600)
                    n_ticks = 600;
                if (n_ticks >= full)
                    prev_drv = clamped;
                repeat (n_ticks)
                    send_item(hpd_pkg::OP_TICK, $urandom_range(0, 1023));
                items_done += n_ticks;
            end
        end

        // longest dead time: once a reversal starts a sequence, the bridge stays in it
        set_dead_time(65535, 16777215);
        repeat (10)
        begin
            send_item(hpd_pkg::OP_DRIVE, $urandom_range(0, 1023));
            repeat ($urandom_range(1, 4))
                send_item(hpd_pkg::OP_TICK, $urandom_range(0, 1023));
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
